FILE: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/mcrc_pkg.sv
// constants, codes and crc byte fold functions of the multi crc engine
package mcrc_pkg;

	localparam int CRC_W = 64;
	localparam int HALF_W = 32;
	localparam int BYTE_W = 8;
	localparam int SEL_W = 2;

	// algorithm selector codes
	localparam logic [SEL_W-1:0] ALG_CRC32 = 2'd0;
	localparam logic [SEL_W-1:0] ALG_CRC32C = 2'd1;
	localparam logic [SEL_W-1:0] ALG_CRC64 = 2'd2;

	// reflected polynomials
	localparam logic [HALF_W-1:0] POLY_CRC32 = 32'hEDB8_8320;
	localparam logic [HALF_W-1:0] POLY_CRC32C = 32'h82F6_3B78;
	localparam logic [CRC_W-1:0] POLY_CRC64 = 64'h9A6C_9329_AC4B_C9B5;

	localparam logic [CRC_W-1:0] CRC_INIT = {CRC_W{1'b1}};

	typedef logic [CRC_W-1:0] crc_t;

	// the 64-bit engine is picked by bit 1 of the selector, so code three acts as crc-64
	function automatic logic is_wide(input logic [SEL_W-1:0] sel);
		logic wide;
		begin
			unique case (sel)
				ALG_CRC32: wide = 1'b0;
				ALG_CRC32C: wide = 1'b0;
				default: wide = 1'b1;
			endcase
			return wide;
		end
	endfunction

	// fold one byte into the register, lsb first, eight shift steps
	function automatic crc_t crc_fold(input crc_t crc, input logic [BYTE_W-1:0] data,
			input logic [SEL_W-1:0] sel);
		crc_t c;
		crc_t poly;
		begin
			unique case (sel)
				ALG_CRC32: poly = {{(CRC_W-HALF_W){1'b0}}, POLY_CRC32};
				ALG_CRC32C: poly = {{(CRC_W-HALF_W){1'b0}}, POLY_CRC32C};
				default: poly = POLY_CRC64;
			endcase
			c = is_wide(sel) ? crc : {{(CRC_W-HALF_W){1'b0}}, crc[HALF_W-1:0]};
			c = c ^ {{(CRC_W-BYTE_W){1'b0}}, data};
			for (int k = 0; k < BYTE_W; k++) begin
				c = {1'b0, c[CRC_W-1:1]} ^ (c[0] ? poly : '0);
			end
			return c;
		end
	endfunction

	// output xor; narrow modes keep the upper half at zero
	function automatic crc_t crc_finish(input crc_t crc, input logic [SEL_W-1:0] sel);
		begin
			if (is_wide(sel)) begin
				return ~crc;
			end
			return {{(CRC_W-HALF_W){1'b0}}, ~crc[HALF_W-1:0]};
		end
	endfunction

endpackage

FILE: rtl/mcrc_intf.sv
// valid/ready channel interfaces for input bytes, results and configuration

interface mcrc_in_if;
	logic valid;
	logic ready;
	logic [mcrc_pkg::BYTE_W-1:0] data_byte;
	logic byte_present;
	logic end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

interface mcrc_out_if;
	logic valid;
	logic ready;
	logic [mcrc_pkg::CRC_W-1:0] crc_value;

	modport source (output valid, output crc_value, input ready);
	modport sink (input valid, input crc_value, output ready);
endinterface

interface mcrc_cfg_if;
	logic valid;
	logic ready;
	logic [mcrc_pkg::SEL_W-1:0] algorithm_select;

	modport source (output valid, output algorithm_select, input ready);
	modport sink (input valid, input algorithm_select, output ready);
endinterface

FILE: rtl/multi_crc_byte_engine.sv
// Byte-wise reflected crc engine: crc-32, crc-32c or crc-64/nvme, one byte per cycle.
// Each item is first held in the input register; a closing item then loads its result into
// the output register once any earlier result has left it.
// Throughput: one item per cycle; only a stalled result blocks the next closing item.
// Reset (arst_n low, asynchronous): crc-32 selected, crc register all ones, channels empty.
// A configuration write restarts the message with the crc register at all ones.
module multi_crc_byte_engine (
	input logic clk,
	input logic arst_n,
	mcrc_in_if.sink in_chan,
	mcrc_out_if.source out_chan,
	mcrc_cfg_if.sink cfg_chan
);

	logic [mcrc_pkg::SEL_W-1:0] sel_q;
	mcrc_pkg::crc_t crc_q;

	// input register
	logic valid_s1;
	logic [mcrc_pkg::BYTE_W-1:0] byte_s1;
	logic present_s1;
	logic last_s1;

	// result register
	logic out_valid_q;
	mcrc_pkg::crc_t out_crc_q;

	logic advance_s1;
	mcrc_pkg::crc_t folded;

	// the stage moves on unless it closes a message while the result is still stalled
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid_q || out_chan.ready);
	assign in_chan.ready = !valid_s1 || advance_s1;
	assign cfg_chan.ready = 1'b1;

	assign folded = present_s1 ? mcrc_pkg::crc_fold(crc_q, byte_s1, sel_q) : crc_q;

	assign out_chan.valid = out_valid_q;
	assign out_chan.crc_value = out_crc_q;

	// control: selector, crc state and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= mcrc_pkg::ALG_CRC32;
			crc_q <= mcrc_pkg::CRC_INIT;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_chan.ready) begin
				valid_s1 <= in_chan.valid;
			end
			if (cfg_chan.valid) begin
				sel_q <= cfg_chan.algorithm_select;
				crc_q <= mcrc_pkg::CRC_INIT;
			end else if (advance_s1) begin
				crc_q <= last_s1 ? mcrc_pkg::CRC_INIT : folded;
			end
			if (advance_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_chan.valid && in_chan.ready) begin
			byte_s1 <= in_chan.data_byte;
			present_s1 <= in_chan.byte_present;
			last_s1 <= in_chan.end_of_message;
		end
		if (advance_s1 && last_s1) begin
			out_crc_q <= mcrc_pkg::crc_finish(folded, sel_q);
		end
	end

endmodule

FILE: rtl/mcrc_checker.sv
// port-level checker for the multi crc engine and its bind
`include "assert_macros.svh"

module mcrc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_end,
	input logic out_valid,
	input logic out_ready,
	input logic [mcrc_pkg::CRC_W-1:0] crc_value,
	input logic cfg_ready
);

	logic close_xfer;
	logic out_free;
	logic out_stall;

	assign close_xfer = in_valid && in_ready && in_end;
	assign out_free = !out_valid || out_ready;
	assign out_stall = out_valid && !out_ready;

	// input side never stalls while the result register can drain
	`ASSERT_SAME(a_in_ready_free, clk, arst_n, out_free, in_ready, "input stalled, output free")

	// a new result follows a closing input transfer that passed through the input register
	`ASSERT_SAME(a_result_source, clk, arst_n, $rose(out_valid), $past(close_xfer, 2), "orphan result")

	// a stalled result stays valid
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid, "stalled result dropped")

	// a stalled result holds its value
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(crc_value), "stalled result changed")

	// configuration writes are always taken
	`ASSERT_ALWAYS(a_cfg_ready, clk, arst_n, cfg_ready, "configuration port not ready")

endmodule

bind multi_crc_byte_engine mcrc_checker u_mcrc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_chan.valid),
	.in_ready(in_chan.ready),
	.in_end(in_chan.end_of_message),
	.out_valid(out_chan.valid),
	.out_ready(out_chan.ready),
	.crc_value(out_chan.crc_value),
	.cfg_ready(cfg_chan.ready)
);

FILE: sim/multi_crc_byte_engine_tb.sv
`timescale 1ns / 100ps
// testbench for the multi crc byte engine: directed and random byte messages checked against a crc predictor
module multi_crc_byte_engine_tb;

	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam int SEGMENT_ITEMS = 115;
	localparam int PHASES = 3;
	localparam int MODES = 4;
	localparam int UPPER_W = mcrc_pkg::CRC_W - mcrc_pkg::HALF_W;

	// selector code three has no name in the package; it decodes as crc-64
	localparam logic [mcrc_pkg::SEL_W-1:0] ALG_SPARE_WIDE = 2'd3;

	typedef logic [mcrc_pkg::BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic [mcrc_pkg::BYTE_W-1:0] data_byte;
		logic byte_present;
		logic end_of_message;
	} byte_item_t;

	logic clk;
	logic arst_n;

	mcrc_in_if in_chan ();
	mcrc_out_if out_chan ();
	mcrc_cfg_if cfg_chan ();

	multi_crc_byte_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_chan(in_chan),
		.out_chan(out_chan),
		.cfg_chan(cfg_chan)
	);

	byte_item_t pending_items[$];
	mcrc_pkg::crc_t crc_expected[$];
	byte_item_t next_item;

	// predictor state
	logic [mcrc_pkg::SEL_W-1:0] alg_sel = mcrc_pkg::ALG_CRC32;
	mcrc_pkg::crc_t crc_running = mcrc_pkg::CRC_INIT;

	logic in_accepted = 1'b0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int cycle_count = 0;
	int error_count = 0;
	int items_taken = 0;
	int results_checked = 0;
	int alg_writes = 0;

	// clock, 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// fold one byte lsb first; bit 1 of the selector picks the 64-bit polynomial
	function automatic mcrc_pkg::crc_t fold_crc_byte(input mcrc_pkg::crc_t acc,
			input logic [mcrc_pkg::BYTE_W-1:0] b, input logic [mcrc_pkg::SEL_W-1:0] sel);
		mcrc_pkg::crc_t poly;
		mcrc_pkg::crc_t c;
		if (sel[1]) begin
			poly = mcrc_pkg::POLY_CRC64;
		end else if (sel[0]) begin
			poly = {{UPPER_W{1'b0}}, mcrc_pkg::POLY_CRC32C};
		end else begin
			poly = {{UPPER_W{1'b0}}, mcrc_pkg::POLY_CRC32};
		end
		c = sel[1] ? acc : {{UPPER_W{1'b0}}, acc[mcrc_pkg::HALF_W-1:0]};
		c = c ^ {{(mcrc_pkg::CRC_W-mcrc_pkg::BYTE_W){1'b0}}, b};
		for (int k = 0; k < mcrc_pkg::BYTE_W; k++) begin
			c = (c >> 1) ^ (c[0] ? poly : '0);
		end
		return c;
	endfunction

	function automatic void report_mismatch(input string what, input mcrc_pkg::crc_t exp_val,
			input mcrc_pkg::crc_t act_val);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("%0t: %s: expected %h, got %h", $time, what, exp_val, act_val);
		end
	endfunction

	// input driver: hold valid until the transfer, then load the next item or idle
	always @(negedge clk) begin
		if (!in_chan.valid || in_accepted) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_item = pending_items.pop_front();
				in_chan.valid <= 1'b1;
				in_chan.data_byte <= next_item.data_byte;
				in_chan.byte_present <= next_item.byte_present;
				in_chan.end_of_message <= next_item.end_of_message;
			end else begin
				in_chan.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// monitor: predict on input transfers, check on result transfers
	always @(posedge clk) begin
		in_accepted <= in_chan.valid && in_chan.ready;
		if (!arst_n) begin
			alg_sel = mcrc_pkg::ALG_CRC32;
			crc_running = mcrc_pkg::CRC_INIT;
		end else begin
			// any algorithm write restarts the message
			if (cfg_chan.valid && cfg_chan.ready) begin
				alg_sel = cfg_chan.algorithm_select;
				crc_running = mcrc_pkg::CRC_INIT;
				alg_writes++;
			end
			if (in_chan.valid && in_chan.ready) begin
				items_taken++;
				if (in_chan.byte_present) begin
					crc_running = fold_crc_byte(crc_running, in_chan.data_byte, alg_sel);
				end
				if (in_chan.end_of_message) begin
					if (alg_sel[1]) begin
						crc_expected.push_back(~crc_running);
					end else begin
						crc_expected.push_back({{UPPER_W{1'b0}},
							~crc_running[mcrc_pkg::HALF_W-1:0]});
					end
					crc_running = mcrc_pkg::CRC_INIT;
				end
			end
			if (out_chan.valid && out_chan.ready) begin
				if (crc_expected.size() == 0) begin
					report_mismatch("result with none expected", '0, out_chan.crc_value);
				end else begin
					results_checked++;
					if (out_chan.crc_value !== crc_expected[0]) begin
						report_mismatch("crc_value", crc_expected[0], out_chan.crc_value);
					end
					void'(crc_expected.pop_front());
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles", cycle_count);
			$display("multi_crc_byte_engine_tb: errors");
			$finish;
		end
	end

	task automatic queue_item(input logic [mcrc_pkg::BYTE_W-1:0] data, input logic present,
			input logic last);
		byte_item_t it;
		it.data_byte = data;
		it.byte_present = present;
		it.end_of_message = last;
		pending_items.push_back(it);
	endtask

	// wait until every item is taken and every result is back, then let the pipe empty
	task automatic drain();
		while (pending_items.size() != 0 || in_chan.valid || crc_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_algorithm(input logic [mcrc_pkg::SEL_W-1:0] sel);
		@(negedge clk);
		cfg_chan.valid <= 1'b1;
		cfg_chan.algorithm_select <= sel;
		@(posedge clk);
		while (!cfg_chan.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		cfg_chan.valid <= 1'b0;
	endtask

	// random messages, mostly short, ended by the last byte or by an end-only transfer
	task automatic fill_segment(input int target);
		int count;
		int nbytes;
		int roll;
		logic end_on_byte;
		count = 0;
		while (count < target) begin
			roll = $urandom_range(99);
			if (roll < 5) begin
				// idle item, ignored by the block
				queue_item(byte_t'($urandom_range(255)), 1'b0, 1'b0);
			end else if (roll < 12) begin
				// bare end: empty message
				queue_item(byte_t'($urandom_range(255)), 1'b0, 1'b1);
				count++;
			end else begin
				nbytes = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
				end_on_byte = 1'($urandom_range(1));
				for (int k = 0; k < nbytes; k++) begin
					queue_item(byte_t'($urandom_range(255)), 1'b1,
						end_on_byte && (k == nbytes - 1));
					count++;
				end
				if (!end_on_byte) begin
					queue_item(byte_t'($urandom_range(255)), 1'b0, 1'b1);
					count++;
				end
			end
		end
		// sometimes leave a message open so the next write lands mid-message
		if ($urandom_range(3) == 0) begin
			nbytes = $urandom_range(5, 1);
			for (int k = 0; k < nbytes; k++) begin
				queue_item(byte_t'($urandom_range(255)), 1'b1, 1'b0);
			end
		end
	endtask

	initial begin
		logic [mcrc_pkg::SEL_W-1:0] sel_order [MODES];
		sel_order[0] = mcrc_pkg::ALG_CRC32;
		sel_order[1] = mcrc_pkg::ALG_CRC32C;
		sel_order[2] = mcrc_pkg::ALG_CRC64;
		sel_order[3] = ALG_SPARE_WIDE;
		in_chan.valid = 1'b0;
		in_chan.data_byte = '0;
		in_chan.byte_present = 1'b0;
		in_chan.end_of_message = 1'b0;
		out_chan.ready = 1'b0;
		cfg_chan.valid = 1'b0;
		cfg_chan.algorithm_select = mcrc_pkg::ALG_CRC32;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 28;
		rx_idle_pct = 72;

		// directed: crc-32 from reset, end-only close, empty message, idle, byte with end
		queue_item(8'h00, 1'b1, 1'b0);
		queue_item(8'hFF, 1'b1, 1'b0);
		queue_item(8'h00, 1'b0, 1'b1);
		queue_item(8'h00, 1'b0, 1'b1);
		queue_item(8'hA5, 1'b0, 1'b0);
		queue_item(8'hA5, 1'b1, 1'b1);
		drain();
		write_algorithm(mcrc_pkg::ALG_CRC32C);
		queue_item(8'h80, 1'b1, 1'b0);
		queue_item(8'h01, 1'b1, 1'b1);
		queue_item(8'hFF, 1'b0, 1'b1);
		drain();
		write_algorithm(mcrc_pkg::ALG_CRC64);
		queue_item(8'hFF, 1'b1, 1'b0);
		queue_item(8'h00, 1'b1, 1'b1);
		queue_item(8'h00, 1'b0, 1'b1);
		// left open: the write below restarts the message
		queue_item(8'h7E, 1'b1, 1'b0);
		drain();
		write_algorithm(ALG_SPARE_WIDE);
		queue_item(8'h00, 1'b0, 1'b1);
		queue_item(8'h5A, 1'b1, 1'b1);
		queue_item(8'hC3, 1'b1, 1'b0);
		drain();
		write_algorithm(mcrc_pkg::ALG_CRC32);
		queue_item(8'hFF, 1'b1, 1'b1);

		// random part: three back-pressure phases, every selector code in each
		for (int phase = 0; phase < PHASES; phase++) begin
			for (int seg = 0; seg < MODES; seg++) begin
				drain();
				case (phase)
					0: begin
						tx_idle_pct = 28;
						rx_idle_pct = 72;
					end
					1: begin
						tx_idle_pct = 72;
						rx_idle_pct = 28;
					end
					default: begin
						tx_idle_pct = 0;
						rx_idle_pct = 0;
					end
				endcase
				write_algorithm(sel_order[(seg + phase) % MODES]);
				fill_segment(SEGMENT_ITEMS);
			end
		end

		drain();
		$display("covered %0d input transfers and %0d crc results across %0d algorithm writes",
			items_taken, results_checked, alg_writes);
		$display("%0d mismatches, %0d results still outstanding", error_count, crc_expected.size());
		if (error_count == 0 && crc_expected.size() == 0) begin
			$display("multi_crc_byte_engine_tb: clean");
		end else begin
			$display("multi_crc_byte_engine_tb: errors");
		end
		$finish;
	end

endmodule
